/* src/stq_pkg.sv */
package stq_pkg;

    // Operation codes carried in the low bits of the input tdata
    localparam logic [1:0] OP_SCHEDULE = 2'd0;
    localparam logic [1:0] OP_TAKE     = 2'd1;
    localparam logic [1:0] OP_FINISH   = 2'd2;

    localparam int OP_W  = 2;
    localparam int ID_W  = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } t_state;

    // Packs LSB first as added, raise_request, granted, granted_id
    typedef struct packed {
        logic [ID_W-1:0] granted_id;
        logic            granted;
        logic            raise_request;
        logic            added;
    } t_result;

endpackage

/* src/serialized_tasklet_queue.sv */
// Deduplicating task queue with per-task queued and running marks.
//
// Input stream (i_s_*): one transfer per operation. tdata[1:0] is the op
// (schedule, take, finish), tdata[5:2] the task id. Output stream (o_m_*):
// exactly one result transfer per accepted operation, in order.
//
// Schedule appends the task to the tail of the order if it is not queued yet,
// and always flags a soft interrupt request. Take walks the order from the
// oldest entry, grants the first task that is not running, and compacts the
// entries behind it in the same pass. Finish clears the running mark.
//
// Sequence: schedule, finish and the unused op pass from ST_IDLE through
// ST_RESULT, which loads the output register once it is free; o_s_tready
// rises as the result is loaded and o_m_tvalid is set. A take passes from
// ST_IDLE through ST_SCAN, which walks every entry of the order (none when
// it is empty), then through ST_RESULT. The pass reads one entry a cycle
// through the single registered read port of the order memory, writes the
// compacted entry back on the write port.
// One operation is in flight at a time; o_s_tready is high only when idle.
// A result waiting on a stalled receiver sits in the output register; the
// next operation is accepted meanwhile and its result is held until the
// output register frees up.
// Reset (synchronous, active low) clears the count and both mark sets; the
// order memory itself is not cleared, only its first count entries are read.
module serialized_tasklet_queue #(
    parameter int MAX_TASKS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // slave side
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [1:0] op, [5:2] task_id, [7:6] zero
    // master side
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [0] added, [1] raise_request, [2] granted,
                                    // [6:3] granted_id, [7] zero
);

    localparam int IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CntW = $clog2(MAX_TASKS + 1);
    localparam logic [8:0] MaxTasksV = 9'(MAX_TASKS);
    localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_TASKS);

    // Control state
    stq_pkg::t_state           r_state, n_state;
    logic [CntW-1:0]           r_cnt, n_cnt;
    logic [MAX_TASKS-1:0]      r_queued, n_queued;
    logic [MAX_TASKS-1:0]      r_running, n_running;
    logic [CntW-1:0]           r_rd, n_rd;
    logic [CntW-1:0]           r_wr, n_wr;
    logic                      r_rvalid, n_rvalid;
    logic                      r_found, n_found;
    logic                      r_out_valid, n_out_valid;

    // Payload
    logic [stq_pkg::ID_W-1:0]  r_gid, n_gid;
    stq_pkg::t_result          r_res, n_res;
    stq_pkg::t_result          r_out, n_out;

    // Order memory and its ports
    logic [stq_pkg::ID_W-1:0]  r_order [MAX_TASKS];
    logic [stq_pkg::ID_W-1:0]  r_rdata;
    logic                      w_en;
    logic [IdxW-1:0]           w_addr;
    logic [stq_pkg::ID_W-1:0]  w_data;
    logic                      rd_en;

    // Decoded input
    logic [stq_pkg::OP_W-1:0]  s_op;
    logic [stq_pkg::ID_W-1:0]  s_id;
    logic [8:0]                s_id_x;
    logic                      s_id_ok;
    logic [IdxW-1:0]           s_idx;

    // Entry under inspection during the take pass
    logic [8:0]                t_x;
    logic [IdxW-1:0]           t_idx;
    logic                      t_runnable;
    logic                      scan_done;
    logic [8:0]                g_x;
    logic [IdxW-1:0]           g_idx;

    assign s_op    = i_s_tdata[1:0];
    assign s_id    = i_s_tdata[5:2];
    assign s_id_x  = {5'd0, s_id};
    assign s_id_ok = s_id_x < MaxTasksV;
    assign s_idx   = s_id_x[IdxW-1:0];

    assign t_x        = {5'd0, r_rdata};
    assign t_idx      = t_x[IdxW-1:0];
    assign t_runnable = !r_found && (t_x < MaxTasksV) && !r_running[t_idx];
    assign scan_done  = (r_rd == r_cnt) && !r_rvalid;
    assign g_x        = {5'd0, r_gid};
    assign g_idx      = g_x[IdxW-1:0];

    assign o_s_tready = (r_state == stq_pkg::ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out};

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_queued    = r_queued;
        n_running   = r_running;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_rvalid    = 1'b0;
        n_found     = r_found;
        n_gid       = r_gid;
        n_res       = r_res;
        n_out       = r_out;
        // drop the output once the receiver takes it
        n_out_valid = r_out_valid && !i_m_tready;
        w_en        = 1'b0;
        w_addr      = r_cnt[IdxW-1:0];
        w_data      = s_id;
        rd_en       = 1'b0;

        case (r_state)
            stq_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_res   = '0;
                    n_state = stq_pkg::ST_RESULT;
                    case (s_op)
                        stq_pkg::OP_SCHEDULE: begin
                            n_res.raise_request = 1'b1;
                            if (s_id_ok && !r_queued[s_idx] && (r_cnt < MaxCnt)) begin
                                // append at the tail
                                n_queued[s_idx] = 1'b1;
                                w_en            = 1'b1;
                                n_cnt           = r_cnt + CntW'(1);
                                n_res.added     = 1'b1;
                            end
                        end
                        stq_pkg::OP_TAKE: begin
                            n_rd    = '0;
                            n_wr    = '0;
                            n_found = 1'b0;
                            n_gid   = '0;
                            n_state = stq_pkg::ST_SCAN;
                        end
                        stq_pkg::OP_FINISH: begin
                            if (s_id_ok) begin
                                n_running[s_idx] = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            stq_pkg::ST_SCAN: begin
                // issue the next read, one entry ahead of the compare
                if (r_rd < r_cnt) begin
                    rd_en    = 1'b1;
                    n_rd     = r_rd + CntW'(1);
                    n_rvalid = 1'b1;
                end
                // grant the first runnable entry, write every other one back compacted
                if (r_rvalid) begin
                    if (t_runnable) begin
                        n_found = 1'b1;
                        n_gid   = r_rdata;
                    end else begin
                        w_en   = 1'b1;
                        w_addr = r_wr[IdxW-1:0];
                        w_data = r_rdata;
                        n_wr   = r_wr + CntW'(1);
                    end
                end
                if (scan_done) begin
                    n_res   = '0;
                    n_state = stq_pkg::ST_RESULT;
                    if (r_found) begin
                        n_cnt              = r_cnt - CntW'(1);
                        n_queued[g_idx]    = 1'b0;
                        n_running[g_idx]   = 1'b1;
                        n_res.granted      = 1'b1;
                        n_res.granted_id   = r_gid;
                    end
                end
            end
            stq_pkg::ST_RESULT: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_m_tready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = stq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stq_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_queued    <= '0;
            r_running   <= '0;
            r_rd        <= '0;
            r_wr        <= '0;
            r_rvalid    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_queued    <= n_queued;
            r_running   <= n_running;
            r_rd        <= n_rd;
            r_wr        <= n_wr;
            r_rvalid    <= n_rvalid;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gid <= n_gid;
        r_res <= n_res;
        r_out <= n_out;
    end

    // Order memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_order[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rdata <= r_order[r_rd[IdxW-1:0]];
        end
    end

endmodule

/* src/stq_checker.sv */
module stq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       i_s_tready,
    input logic       i_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] i_m_tdata
);

    // A result waiting on a stalled receiver stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> i_m_tvalid)
        else $error("stq: result withdrawn while stalled");

    // Only one operation in flight: ready drops after every input transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> !i_s_tready)
        else $error("stq: ready held after accepting an operation");

    // Schedule and take results never mix, and an unset grant carries id zero
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (!(i_m_tdata[1] && i_m_tdata[2]) && (i_m_tdata[1] || !i_m_tdata[0])
                        && (i_m_tdata[2] || (i_m_tdata[6:3] == 4'd0))))
        else $error("stq: inconsistent result fields");

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_m_tvalid)
        else $error("stq: result presented right after reset");

endmodule

bind serialized_tasklet_queue stq_checker u_stq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);

/* dv/tb_serialized_tasklet_queue.sv */
`timescale 1ns / 100ps

module tb_serialized_tasklet_queue;

    localparam int         N_TASKS    = 16;
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         RAND_ITEMS = 2000;
    localparam int         PHASE_LEN  = 100;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata  = '0;
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;

    // Tracks the pending order and both mark sets, and holds the outcome that each
    // accepted operation must produce, oldest first.
    class tasklet_order_tracker;
        logic [stq_pkg::ID_W-1:0] order[$];
        logic [N_TASKS-1:0] queued;
        logic [N_TASKS-1:0] running;
        stq_pkg::t_result expected_outcomes[$];
        int fails;

        function new();
            queued  = '0;
            running = '0;
            fails   = 0;
        endfunction

        function stq_pkg::t_result predict_outcome(logic [1:0] op,
                                                   logic [stq_pkg::ID_W-1:0] id);
            stq_pkg::t_result r;
            int pos;
            r   = '0;
            pos = -1;
            case (op)
                stq_pkg::OP_SCHEDULE: begin
                    r.raise_request = 1'b1;
                    if (!queued[id]) begin
                        queued[id] = 1'b1;
                        order.push_back(id);
                        r.added = 1'b1;
                    end
                end
                stq_pkg::OP_TAKE: begin
                    // oldest entry whose task is not running; the id field is ignored
                    foreach (order[i])
                        if (pos < 0 && !running[order[i]])
                            pos = i;
                    if (pos >= 0) begin
                        r.granted    = 1'b1;
                        r.granted_id = order[pos];
                        queued[order[pos]]  = 1'b0;
                        running[order[pos]] = 1'b1;
                        order.delete(pos);
                    end
                end
                stq_pkg::OP_FINISH: begin
                    running[id] = 1'b0;
                end
                default: begin
                end
            endcase
            return r;
        endfunction

        function void note_op(logic [1:0] op, logic [stq_pkg::ID_W-1:0] id);
            expected_outcomes.push_back(predict_outcome(op, id));
        endfunction

        task report(string what, int want, int got);
            if (fails < 50)
                $display("mismatch on %s: expected %0d, got %0d", what, want, got);
            fails++;
        endtask

        task check_outcome(stq_pkg::t_result got);
            stq_pkg::t_result want;
            if (expected_outcomes.size() == 0) begin
                report("result with nothing outstanding, tdata", 0, int'(got));
                return;
            end
            want = expected_outcomes.pop_front();
            if (got.added != want.added)
                report("added", want.added, got.added);
            if (got.raise_request != want.raise_request)
                report("raise_request", want.raise_request, got.raise_request);
            if (got.granted != want.granted)
                report("granted", want.granted, got.granted);
            if (got.granted_id != want.granted_id)
                report("granted_id", want.granted_id, got.granted_id);
        endtask
    endclass

    tasklet_order_tracker tracker = new();

    int burst_left = 1;

    serialized_tasklet_queue #(
        .MAX_TASKS (N_TASKS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),     // [1:0] op, [5:2] task_id, [7:6] zero
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)      // [0] added, [1] raise_request, [2] granted,
                                     // [6:3] granted_id, [7] zero
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Present one operation and hold it until the block takes the transfer.
    task automatic send_op(logic [1:0] op, logic [stq_pkg::ID_W-1:0] id);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, id, op};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        tracker.note_op(op, id);
    endtask

    // Close a burst now and then: drop valid for a random gap, or run straight on.
    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left > 0)
            return;
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 12);
        if ($urandom_range(0, 3) == 0)
            return;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 5);
        i_s_tvalid <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    // Fill-heavy phases push the order towards all sixteen tasks queued;
    // drain-heavy phases empty it and hit takes with nothing runnable.
    function automatic logic [1:0] pick_op(bit fill_heavy);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return OP_UNUSED;
        if (fill_heavy) begin
            if (roll < 60) return stq_pkg::OP_SCHEDULE;
            if (roll < 80) return stq_pkg::OP_TAKE;
            return stq_pkg::OP_FINISH;
        end
        if (roll < 25) return stq_pkg::OP_SCHEDULE;
        if (roll < 70) return stq_pkg::OP_TAKE;
        return stq_pkg::OP_FINISH;
    endfunction

    // Mostly finish a task that is really running, so lifecycles complete.
    function automatic logic [stq_pkg::ID_W-1:0] pick_finish_id();
        logic [stq_pkg::ID_W-1:0] id;
        id = stq_pkg::ID_W'($urandom_range(0, N_TASKS - 1));
        if (tracker.running != '0 && $urandom_range(0, 4) != 0)
            while (!tracker.running[id])
                id = stq_pkg::ID_W'($urandom_range(0, N_TASKS - 1));
        return id;
    endfunction

    initial begin
        logic [1:0]               op;
        logic [stq_pkg::ID_W-1:0] id;
        bit                       fill_heavy;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty take, duplicate schedule, reschedule of a running task,
        // take finding only a running task, finishes with and without effect, unused op.
        send_op(stq_pkg::OP_TAKE,     4'd15);  pace_sender();
        send_op(stq_pkg::OP_SCHEDULE, 4'd0);   pace_sender();
        send_op(stq_pkg::OP_SCHEDULE, 4'd15);  pace_sender();
        send_op(stq_pkg::OP_SCHEDULE, 4'd0);   pace_sender();
        send_op(stq_pkg::OP_TAKE,     4'd10);  pace_sender();
        send_op(stq_pkg::OP_SCHEDULE, 4'd0);   pace_sender();
        send_op(stq_pkg::OP_TAKE,     4'd0);   pace_sender();
        send_op(stq_pkg::OP_TAKE,     4'd5);   pace_sender();
        send_op(stq_pkg::OP_FINISH,   4'd5);   pace_sender();
        send_op(stq_pkg::OP_FINISH,   4'd0);   pace_sender();
        send_op(stq_pkg::OP_TAKE,     4'd0);   pace_sender();
        send_op(OP_UNUSED,            4'd15);  pace_sender();
        send_op(OP_UNUSED,            4'd0);   pace_sender();
        send_op(stq_pkg::OP_FINISH,   4'd15);  pace_sender();
        send_op(stq_pkg::OP_FINISH,   4'd0);   pace_sender();
        send_op(stq_pkg::OP_SCHEDULE, 4'd10);  pace_sender();
        send_op(stq_pkg::OP_SCHEDULE, 4'd5);   pace_sender();
        send_op(stq_pkg::OP_SCHEDULE, 4'd10);  pace_sender();
        send_op(stq_pkg::OP_TAKE,     4'd15);  pace_sender();
        send_op(stq_pkg::OP_TAKE,     4'd15);  pace_sender();
        send_op(stq_pkg::OP_TAKE,     4'd15);  pace_sender();
        send_op(stq_pkg::OP_FINISH,   4'd10);  pace_sender();
        send_op(stq_pkg::OP_FINISH,   4'd5);   pace_sender();

        for (int n = 0; n < RAND_ITEMS; n++) begin
            fill_heavy = ((n / PHASE_LEN) % 2) == 0;
            op = pick_op(fill_heavy);
            id = (op == stq_pkg::OP_FINISH) ? pick_finish_id()
                                            : stq_pkg::ID_W'($urandom_range(0, N_TASKS - 1));
            send_op(op, id);
            pace_sender();
        end
        i_s_tvalid <= 1'b0;

        // Drain, then allow for a late stray result.
        while (tracker.expected_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (tracker.fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Receiver: switch between always ready, random stalls, sparse ready and a
    // periodic stall, each held for a random stretch.
    initial begin
        stq_pkg::t_result seen;
        int               stall_mode;
        int               mode_left;
        int               cycle_ct;
        stall_mode = 0;
        mode_left  = 0;
        cycle_ct   = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                seen = o_m_tdata[6:0];
                tracker.check_outcome(seen);
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(64, 256);
            end
            mode_left--;
            cycle_ct++;
            case (stall_mode)
                0:       i_m_tready <= 1'b1;
                1:       i_m_tready <= 1'($urandom_range(0, 1));
                2:       i_m_tready <= ($urandom_range(0, 3) == 0);
                default: i_m_tready <= (cycle_ct % 16) < 10;
            endcase
        end
    end

    initial begin
        #1_500_000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
src/stq_pkg.sv
src/serialized_tasklet_queue.sv
src/stq_checker.sv
dv/tb_serialized_tasklet_queue.sv
